@@ design/scalc_pkg.sv @@
// Shared types, command and status codes, and the factorial table for the stack calculator.
// It has no dependencies. scalc_div and the top level in design/ refer to it by scoped names.
package scalc_pkg;

    localparam int DATA_W             = 16;
    localparam int STACK_CAPACITY_DEF = 31;

    // command codes
    localparam logic [7:0] FN_PUSH  = 8'd1;
    localparam logic [7:0] FN_PORT  = 8'd2;
    localparam logic [7:0] FN_LOG   = 8'd3;
    localparam logic [7:0] FN_TOP   = 8'd4;
    localparam logic [7:0] FN_DUMP  = 8'd5;
    localparam logic [7:0] FN_DUP   = 8'd6;
    localparam logic [7:0] FN_SWAP  = 8'd7;
    localparam logic [7:0] FN_NEG   = 8'd8;
    localparam logic [7:0] FN_FACT  = 8'd9;
    localparam logic [7:0] FN_SUM   = 8'd10;
    localparam logic [7:0] FN_ADD   = 8'd11;
    localparam logic [7:0] FN_SUB   = 8'd12;
    localparam logic [7:0] FN_MUL   = 8'd13;
    localparam logic [7:0] FN_DIV   = 8'd14;
    localparam logic [7:0] FN_MOD   = 8'd15;
    localparam logic [7:0] FN_AND   = 8'd16;
    localparam logic [7:0] FN_OR    = 8'd17;
    localparam logic [7:0] FN_SHL   = 8'd18;
    localparam logic [7:0] FN_ASR   = 8'd19;
    localparam logic [7:0] FN_CLEAR = 8'd254;
    localparam logic [7:0] FN_HALT  = 8'd255;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_HALTED   = 3'd4;

    typedef struct packed {
        logic [7:0]         func;
        logic signed [15:0] operand;
    } cmd_item_t;

    typedef struct packed {
        logic               is_status;
        logic [15:0]        port;
        logic signed [15:0] value;
        logic [2:0]         status;
        logic               last;
    } res_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_TOP_OUT,
        S_RD_SEC,
        S_SWAP2,
        S_DIV,
        S_DUMP,
        S_SUM,
        S_STATUS
    } seq_state_t;

    // n! modulo 2^16; zero from 18 upwards, one for n <= 0
    function automatic logic [15:0] fact16(input logic [15:0] n);
        logic [15:0] r;
        r = 16'd0;
        if (n[15] || n < 16'd2) begin
            r = 16'd1;
        end else if (n < 16'd18) begin
            unique case (n[4:0])
                5'd2:    r = 16'd2;
                5'd3:    r = 16'd6;
                5'd4:    r = 16'd24;
                5'd5:    r = 16'd120;
                5'd6:    r = 16'd720;
                5'd7:    r = 16'd5040;
                5'd8:    r = 16'd40320;
                5'd9:    r = 16'd35200;
                5'd10:   r = 16'd24320;
                5'd11:   r = 16'd5376;
                5'd12:   r = 16'd64512;
                5'd13:   r = 16'd52224;
                5'd14:   r = 16'd10240;
                5'd15:   r = 16'd22528;
                5'd16:   r = 16'd32768;
                5'd17:   r = 16'd32768;
                default: r = 16'd1;
            endcase
        end
        return r;
    endfunction

endpackage

@@ design/scalc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module scalc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/scalc_div.sv @@
// Signed 16-bit restoring divider that produces one quotient bit per cycle and truncates toward zero.
// It depends on scalc_pkg for the data width.
module scalc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quot,
    output logic [15:0] rem
);

    localparam int W = scalc_pkg::DATA_W;

    logic [W-1:0]             q_reg, q_next;
    logic [W:0]               r_reg, r_next;
    logic [W-1:0]             d_reg, d_next;
    logic [$clog2(W+1)-1:0]   cnt_reg, cnt_next;
    logic                     qneg_reg, qneg_next;
    logic                     rneg_reg, rneg_next;
    logic                     done_reg, done_next;
    logic [W:0]               trial;

    // one restoring step per cycle on the magnitudes
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        trial     = {r_reg[W-1:0], q_reg[W-1]};
        if (start)
        begin
            q_next    = dividend[W-1] ? W'(-dividend) : dividend;
            d_next    = divisor[W-1] ? W'(-divisor) : divisor;
            r_next    = '0;
            cnt_next  = ($clog2(W+1))'(W);
            qneg_next = dividend[W-1] ^ divisor[W-1];
            rneg_next = dividend[W-1];
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ($clog2(W+1))'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quot = qneg_reg ? W'(-q_reg) : q_reg;
    assign rem  = rneg_reg ? W'(-r_reg[W-1:0]) : r_reg[W-1:0];

endmodule

@@ design/stack_calculator_engine_core.sv @@
// Top level of the 16-bit stack calculator. It contains the command sequencer and the output register.
// It depends on scalc_pkg, scalc_ram (the stack store) and scalc_div (the divider).
//
// Usage:
//  The cmd channel carries one item per command: a function code and a signed operand.
//  The res channel returns, for each command, zero or more data items and then one status item
//  with last set. Both channels use valid/stall handshakes.
//  A command is accepted only while the sequencer is idle, so the engine processes one command at a time.
//  Because the stack lives in a RAM with a registered read, the steps depend on the command:
//   push, port, log, clear, halt and invalid codes go straight to the status item;
//   top, dup, negate and factorial first read the top entry; swap and the binary operations read two;
//   div and mod then wait for the bit-serial divider;
//   dump and sum-all make one RAM read per entry.
//  Results go through a single output register. While res_stall holds a valid item there, the sequencer
//  waits before emitting its next item, and no item is lost.
//  Reset leaves the stack empty, the output port at 0, the log port at 1 and the engine not halted.
//  The stack RAM contents are not cleared at reset.
module stack_calculator_engine_core #(
    parameter int STACK_CAPACITY = scalc_pkg::STACK_CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  scalc_pkg::cmd_item_t  cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output scalc_pkg::res_item_t  res
);

    localparam int AW = $clog2(STACK_CAPACITY);
    localparam int DW = $clog2(STACK_CAPACITY + 1);
    localparam logic [DW-1:0] CAP = DW'(STACK_CAPACITY);

    scalc_pkg::seq_state_t state_reg, state_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [15:0]    oport_reg, oport_next;
    logic [15:0]    lport_reg, lport_next;
    logic           halted_reg, halted_next;
    logic [15:0]    sport_reg, sport_next;
    logic [2:0]     err_reg, err_next;
    logic [7:0]     func_reg, func_next;
    logic [15:0]    top_reg, top_next;
    logic [15:0]    sec_reg, sec_next;
    logic [15:0]    acc_reg, acc_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           res_valid_reg, res_valid_next;
    scalc_pkg::res_item_t res_reg, res_next;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [15:0]    ram_wdata, ram_rdata;
    logic           div_start, div_done;
    logic [15:0]    div_quot, div_rem;
    logic           accept, slot_free, emit;
    scalc_pkg::res_item_t emit_item;
    logic [15:0]    binres;
    logic [AW-1:0]  top_addr, sec_addr;

    scalc_ram #(
        .WIDTH (scalc_pkg::DATA_W),
        .DEPTH (STACK_CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scalc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign accept    = cmd_valid && (state_reg == scalc_pkg::S_IDLE);
    assign cmd_stall = (state_reg != scalc_pkg::S_IDLE);
    assign slot_free = !res_valid_reg || !res_stall;
    assign top_addr  = AW'(depth_reg - 1'b1);
    assign sec_addr  = AW'(depth_reg - DW'(2));

    // binary operation: left operand is the second entry (RAM data), right is the top
    always_comb
    begin
        binres = '0;
        unique case (func_reg)
            scalc_pkg::FN_ADD: binres = ram_rdata + top_reg;
            scalc_pkg::FN_SUB: binres = ram_rdata - top_reg;
            scalc_pkg::FN_MUL: binres = 16'(ram_rdata * top_reg);
            scalc_pkg::FN_AND: binres = ram_rdata & top_reg;
            scalc_pkg::FN_OR:  binres = ram_rdata | top_reg;
            scalc_pkg::FN_SHL: binres = (top_reg >= 16'd16) ? 16'd0 : (ram_rdata << top_reg[3:0]);
            scalc_pkg::FN_ASR: binres = (top_reg >= 16'd16) ? {16{ram_rdata[15]}}
                                      : 16'($signed(ram_rdata) >>> top_reg[3:0]);
            default:           binres = '0;
        endcase
    end

    // sequencer: next state, stack accesses and result generation
    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        oport_next  = oport_reg;
        lport_next  = lport_reg;
        halted_next = halted_reg;
        sport_next  = sport_reg;
        err_next    = err_reg;
        func_next   = func_reg;
        top_next    = top_reg;
        sec_next    = sec_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        ram_we      = 1'b0;
        ram_waddr   = top_addr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = top_addr;
        div_start   = 1'b0;
        emit        = 1'b0;
        emit_item   = '{is_status: 1'b0, port: oport_reg, value: '0, status: scalc_pkg::ST_OK,
                        last: 1'b0};

        unique case (state_reg)
            scalc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = cmd.func;
                    sport_next = lport_reg;
                    err_next   = scalc_pkg::ST_OK;
                    state_next = scalc_pkg::S_STATUS;
                    if (halted_reg)
                    begin
                        err_next = scalc_pkg::ST_HALTED;
                    end
                    else
                    begin
                        priority if (cmd.func == scalc_pkg::FN_PUSH)
                        begin
                            if (depth_reg >= CAP)
                            begin
                                err_next = scalc_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(depth_reg);
                                ram_wdata  = cmd.operand;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        else if (cmd.func == scalc_pkg::FN_PORT)
                        begin
                            oport_next = cmd.operand;
                        end
                        else if (cmd.func == scalc_pkg::FN_LOG)
                        begin
                            lport_next = cmd.operand;
                        end
                        else if (cmd.func == scalc_pkg::FN_CLEAR)
                        begin
                            depth_next = '0;
                        end
                        else if (cmd.func == scalc_pkg::FN_HALT)
                        begin
                            halted_next = 1'b1;
                            err_next    = scalc_pkg::ST_HALTED;
                        end
                        else if (cmd.func == scalc_pkg::FN_DUMP)
                        begin
                            if (depth_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                idx_next   = top_addr;
                                state_next = scalc_pkg::S_DUMP;
                            end
                        end
                        else if (cmd.func == scalc_pkg::FN_SUM)
                        begin
                            if (depth_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                depth_next = DW'(1);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                idx_next   = top_addr;
                                acc_next   = '0;
                                state_next = scalc_pkg::S_SUM;
                            end
                        end
                        else if ((cmd.func >= scalc_pkg::FN_TOP && cmd.func <= scalc_pkg::FN_FACT)
                                 || (cmd.func >= scalc_pkg::FN_ADD
                                     && cmd.func <= scalc_pkg::FN_ASR))
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = scalc_pkg::ST_MISSING;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = scalc_pkg::S_RD_TOP;
                            end
                        end
                        else
                        begin
                            err_next = scalc_pkg::ST_INVALID;
                        end
                    end
                end
            end

            scalc_pkg::S_RD_TOP:
            begin
                top_next   = ram_rdata;
                state_next = scalc_pkg::S_STATUS;
                priority if (func_reg == scalc_pkg::FN_TOP)
                begin
                    state_next = scalc_pkg::S_TOP_OUT;
                end
                else if (func_reg == scalc_pkg::FN_DUP)
                begin
                    if (depth_reg >= CAP)
                    begin
                        err_next = scalc_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(depth_reg);
                        ram_wdata  = ram_rdata;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                else if (func_reg == scalc_pkg::FN_NEG)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = 16'(16'd0 - ram_rdata);
                end
                else if (func_reg == scalc_pkg::FN_FACT)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = scalc_pkg::fact16(ram_rdata);
                end
                else
                begin
                    // swap and binary operations need a second entry
                    if (depth_reg == DW'(1))
                    begin
                        err_next   = scalc_pkg::ST_MISSING;
                        depth_next = '0;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = sec_addr;
                        state_next = scalc_pkg::S_RD_SEC;
                    end
                end
            end

            scalc_pkg::S_TOP_OUT:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_item.value = top_reg;
                    state_next      = scalc_pkg::S_STATUS;
                end
            end

            scalc_pkg::S_RD_SEC:
            begin
                sec_next = ram_rdata;
                priority if (func_reg == scalc_pkg::FN_SWAP)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = sec_addr;
                    ram_wdata  = top_reg;
                    state_next = scalc_pkg::S_SWAP2;
                end
                else if (func_reg == scalc_pkg::FN_DIV || func_reg == scalc_pkg::FN_MOD)
                begin
                    if (top_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = sec_addr;
                        depth_next = depth_reg - 1'b1;
                        state_next = scalc_pkg::S_STATUS;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = scalc_pkg::S_DIV;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = sec_addr;
                    ram_wdata  = binres;
                    depth_next = depth_reg - 1'b1;
                    state_next = scalc_pkg::S_STATUS;
                end
            end

            scalc_pkg::S_SWAP2:
            begin
                ram_we     = 1'b1;
                ram_wdata  = sec_reg;
                state_next = scalc_pkg::S_STATUS;
            end

            scalc_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = sec_addr;
                    ram_wdata  = (func_reg == scalc_pkg::FN_DIV) ? div_quot : div_rem;
                    depth_next = depth_reg - 1'b1;
                    state_next = scalc_pkg::S_STATUS;
                end
            end

            // walk from the top down, one entry per accepted output slot
            scalc_pkg::S_DUMP:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_item.value = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = scalc_pkg::S_STATUS;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - 1'b1;
                    end
                end
            end

            // accumulate every entry, then leave the sum as the only entry
            scalc_pkg::S_SUM:
            begin
                acc_next = acc_reg + ram_rdata;
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = acc_reg + ram_rdata;
                    depth_next = DW'(1);
                    state_next = scalc_pkg::S_STATUS;
                end
                else
                begin
                    idx_next  = idx_reg - 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - 1'b1;
                end
            end

            scalc_pkg::S_STATUS:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_item = '{is_status: 1'b1, port: sport_reg, value: '0,
                                  status: err_reg, last: 1'b1};
                    state_next = scalc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = scalc_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (emit)
        begin
            res_next       = emit_item;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scalc_pkg::S_IDLE;
            depth_reg     <= '0;
            oport_reg     <= 16'd0;
            lport_reg     <= 16'd1;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            oport_reg     <= oport_next;
            lport_reg     <= lport_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sport_reg <= sport_next;
        err_reg   <= err_next;
        func_reg  <= func_next;
        top_reg   <= top_next;
        sec_reg   <= sec_next;
        acc_reg   <= acc_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
